[rtl/rgbled_pkg.sv]
// Package: shared constants and types for the RGB LED strip bit driver.
`default_nettype none
package rgbled_pkg;

	localparam int LED_COUNT_DEF = 64;
	localparam int BITS_PER_LED  = 24;
	localparam int COLOR_W       = 24;
	localparam int TICK_W        = 12;
	localparam int SLOTS_W       = 8;
	localparam int BITPOS_W      = 5;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 12;

	localparam logic [TICK_W-1:0]  PERIOD_RST   = 12'd125;
	localparam logic [TICK_W-1:0]  HIGH_ZERO_RST = 12'd35;
	localparam logic [TICK_W-1:0]  HIGH_ONE_RST = 12'd80;
	localparam logic [SLOTS_W-1:0] RST_SLOTS_RST = 8'd50;

	localparam logic [BITPOS_W-1:0] BIT_LAST = BITPOS_W'(BITS_PER_LED - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PERIOD    = 2'd0,
		CFG_HIGH_ZERO = 2'd1,
		CFG_HIGH_ONE  = 2'd2,
		CFG_RST_SLOTS = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_TICK  = 1'b1
	} cmd_t;

endpackage
`default_nettype wire

[rtl/rgbled_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rgbled_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/rgb_led_strip_bit_driver.sv]
// Top level: one-wire waveform driver for a chain of addressable RGB LEDs.
// Takes one word per clock while in_stall is low: a color write or one timer tick. Each
// accepted word gives one result word, through the color store read and the stage-1
// registers, then the output register. Counters advance when a tick is accepted; the color
// store is a single RAM read that feeds the level decision from stage 1, and per-entry valid
// bits make unwritten LEDs read as black, so no clearing pass is needed after reset.
`default_nettype none
module rgb_led_strip_bit_driver #(
	parameter int LED_COUNT = rgbled_pkg::LED_COUNT_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic                                  command,
	input  wire logic [7:0]                            led_index,
	input  wire logic [7:0]                            red,
	input  wire logic [7:0]                            green,
	input  wire logic [7:0]                            blue,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic                                       line_level,
	output logic                                       write_taken,
	output logic                                       frame_start,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [rgbled_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rgbled_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import rgbled_pkg::*;

	localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam logic [IDX_W-1:0] LED_LAST = IDX_W'(LED_COUNT - 1);
	localparam logic [8:0] LED_LIMIT = 9'(LED_COUNT);

	logic [TICK_W-1:0]  period_q;
	logic [TICK_W-1:0]  high_zero_q;
	logic [TICK_W-1:0]  high_one_q;
	logic [SLOTS_W-1:0] rst_slots_q;

	logic [IDX_W-1:0]    led_q;
	logic [BITPOS_W-1:0] bit_q;
	logic [TICK_W-1:0]   tick_q;
	logic [SLOTS_W-1:0]  gap_cnt_q;
	logic                gap_q;
	logic                slot_bit_q;
	logic                level_q;
	logic [LED_COUNT-1:0] ent_valid_q;

	logic                valid_s1;
	logic                tick_s1;
	logic                latch_s1;
	logic [BITPOS_W-1:0] bitsel_s1;
	logic [TICK_W-1:0]   cnt_s1;
	logic                gap_s1;
	logic                first_s1;
	logic                taken_s1;
	logic                ent_valid_s1;

	logic                out_valid_q;
	logic                line_level_q;
	logic                write_taken_q;
	logic                frame_start_q;

	logic                in_accept;
	logic                adv;
	logic                is_tick;
	logic                wr_ok;
	logic [IDX_W-1:0]    wr_addr;
	logic [COLOR_W-1:0]  rdata;

	logic [IDX_W-1:0]    led_d;
	logic [BITPOS_W-1:0] bit_d;
	logic [TICK_W-1:0]   tick_d;
	logic [SLOTS_W-1:0]  gap_cnt_d;
	logic                gap_d;
	logic [TICK_W:0]     tick_inc;
	logic [SLOTS_W-1:0]  gap_inc;

	logic                new_bit;
	logic                cur_bit;
	logic [TICK_W-1:0]   high_sel;
	logic                level_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RST;
			high_zero_q <= HIGH_ZERO_RST;
			high_one_q  <= HIGH_ONE_RST;
			rst_slots_q <= RST_SLOTS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PERIOD:    period_q    <= cfg_data;
				CFG_HIGH_ZERO: high_zero_q <= cfg_data;
				CFG_HIGH_ONE:  high_one_q  <= cfg_data;
				CFG_RST_SLOTS: rst_slots_q <= cfg_data[SLOTS_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign in_accept = in_valid && !in_stall;
	assign is_tick   = (cmd_t'(command) == CMD_TICK);
	assign wr_ok     = !is_tick && ({1'b0, led_index} < LED_LIMIT);
	assign wr_addr   = led_index[IDX_W-1:0];

	always_comb begin
		led_d     = led_q;
		bit_d     = bit_q;
		gap_cnt_d = gap_cnt_q;
		gap_d     = gap_q;
		tick_inc  = {1'b0, tick_q} + 1'b1;
		gap_inc   = gap_cnt_q + 1'b1;
		tick_d    = tick_inc[TICK_W-1:0];
		if (tick_inc >= {1'b0, period_q}) begin
			tick_d = '0;
			if (gap_q) begin
				gap_cnt_d = gap_inc;
				if (gap_inc >= rst_slots_q || gap_inc == '0) begin
					gap_d     = 1'b0;
					gap_cnt_d = '0;
				end
			end else if (bit_q == BIT_LAST) begin
				bit_d = '0;
				if (led_q == LED_LAST) begin
					led_d     = '0;
					gap_cnt_d = '0;
					gap_d     = (rst_slots_q != '0);
				end else begin
					led_d = led_q + 1'b1;
				end
			end else begin
				bit_d = bit_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q       <= '0;
			bit_q       <= '0;
			tick_q      <= '0;
			gap_cnt_q   <= '0;
			gap_q       <= 1'b0;
			ent_valid_q <= '0;
		end else if (in_accept) begin
			if (is_tick) begin
				led_q     <= led_d;
				bit_q     <= bit_d;
				tick_q    <= tick_d;
				gap_cnt_q <= gap_cnt_d;
				gap_q     <= gap_d;
			end else if (wr_ok) begin
				ent_valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	rgbled_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(LED_COUNT)
	) u_color_ram (
		.clk  (clk),
		.we   (in_accept && wr_ok),
		.waddr(wr_addr),
		.wdata({green, red, blue}),
		.re   (in_accept && is_tick),
		.raddr(led_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			tick_s1      <= is_tick;
			latch_s1     <= (tick_q == '0);
			bitsel_s1    <= BIT_LAST - bit_q;
			cnt_s1       <= tick_q;
			gap_s1       <= gap_q;
			first_s1     <= is_tick && !gap_q && led_q == '0 && bit_q == '0 && tick_q == '0;
			taken_s1     <= wr_ok;
			ent_valid_s1 <= ent_valid_q[led_q];
		end
	end

	assign new_bit  = !gap_s1 && ent_valid_s1 && rdata[bitsel_s1];
	assign cur_bit  = latch_s1 ? new_bit : slot_bit_q;
	assign high_sel = cur_bit ? high_one_q : high_zero_q;
	assign level_d  = tick_s1 ? (!gap_s1 && (cnt_s1 < high_sel)) : level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bit_q  <= 1'b0;
			level_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				if (tick_s1) begin
					slot_bit_q <= cur_bit;
					level_q    <= level_d;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			line_level_q  <= level_d;
			write_taken_q <= !tick_s1 && taken_s1;
			frame_start_q <= tick_s1 && first_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign line_level  = line_level_q;
	assign write_taken = write_taken_q;
	assign frame_start = frame_start_q;

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= BIT_LAST)
		else $error("bit position beyond last bit of an LED");

	a_gap_home: assert property (@(posedge clk) disable iff (!arst_n)
		gap_q |-> (led_q == '0 && bit_q == '0))
		else $error("reset gap entered away from frame start");

	a_out_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(write_taken_q && frame_start_q))
		else $error("write and frame start reported together");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && out_stall) |-> !in_accept)
		else $error("word accepted while pipeline is full");

endmodule
`default_nettype wire
